/* sv/kpsd_pkg.sv */
// Shared types, key codes, characters and row patterns for the keypad scanner.
// No dependencies; used by kpsd_key_decode, the top level and the testbench.
package kpsd_pkg;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_SERIAL = 1'b1;

	// Key codes as read back from the port (row nibble, column nibble)
	localparam logic [7:0] KEY_1    = 8'hE7;
	localparam logic [7:0] KEY_2    = 8'hEB;
	localparam logic [7:0] KEY_3    = 8'hED;
	localparam logic [7:0] KEY_4    = 8'hD7;
	localparam logic [7:0] KEY_5    = 8'hDB;
	localparam logic [7:0] KEY_6    = 8'hDD;
	localparam logic [7:0] KEY_7    = 8'hB7;
	localparam logic [7:0] KEY_8    = 8'hBB;
	localparam logic [7:0] KEY_9    = 8'hBD;
	localparam logic [7:0] KEY_STAR = 8'h77;
	localparam logic [7:0] KEY_0    = 8'h7B;
	localparam logic [7:0] KEY_HASH = 8'h7D;

	// ASCII command characters
	localparam logic [7:0] CHR_NONE = 8'h00;
	localparam logic [7:0] CHR_1    = 8'h31;
	localparam logic [7:0] CHR_2    = 8'h32;
	localparam logic [7:0] CHR_3    = 8'h33;
	localparam logic [7:0] CHR_4    = 8'h34;
	localparam logic [7:0] CHR_5    = 8'h35;
	localparam logic [7:0] CHR_6    = 8'h36;
	localparam logic [7:0] CHR_7    = 8'h37;
	localparam logic [7:0] CHR_8    = 8'h38;
	localparam logic [7:0] CHR_9    = 8'h39;
	localparam logic [7:0] CHR_A    = 8'h61;
	localparam logic [7:0] CHR_B    = 8'h62;
	localparam logic [7:0] CHR_C    = 8'h63;

	// Serial LED commands
	localparam logic [7:0] SER_LED_ON  = 8'h64; // 'd': pin low, LED lit
	localparam logic [7:0] SER_LED_OFF = 8'h65; // 'e': pin high, LED dark

	// Mode encodings
	localparam logic MODE_RADIO    = 1'b0;
	localparam logic MODE_TRACTION = 1'b1;

	// Flags the decoder reads and rewrites
	typedef struct packed {
		logic seq_first;
		logic seq_second;
		logic mode;
	} key_state_t;

	// Decoder result
	typedef struct packed {
		logic [7:0] ch;
		logic       blink;
		key_state_t nxt;
	} key_dec_t;

	function automatic logic [7:0] row_pattern(input logic [1:0] idx);
		logic [7:0] pat;
		unique case (idx)
			2'd0: pat = 8'hEF;
			2'd1: pat = 8'hDF;
			2'd2: pat = 8'hBF;
			2'd3: pat = 8'h7F;
		endcase
		return pat;
	endfunction

endpackage

/* sv/kpsd_if.sv */
// Valid/ready channel interfaces for scan items and result items.
// Depends on nothing.
interface kpsd_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface kpsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] row_drive;
	logic       send_valid;
	logic [7:0] send_char;
	logic       blink_pulse;
	logic       led_level;
	logic       control_mode;

	modport source (output valid, output row_drive, output send_valid, output send_char,
		output blink_pulse, output led_level, output control_mode, input ready);
	modport sink   (input valid, input row_drive, input send_valid, input send_char,
		input blink_pulse, input led_level, input control_mode, output ready);
endinterface

/* sv/kpsd_key_decode.sv */
// Key code decoder: command character, mode toggle sequence (star, 0, hash).
// Depends on kpsd_pkg.
module kpsd_key_decode (
	input  logic [7:0]          code,
	input  kpsd_pkg::key_state_t cur,
	output kpsd_pkg::key_dec_t   dec
);

	logic traction;

	assign traction = (cur.mode == kpsd_pkg::MODE_TRACTION);

	always_comb begin
		dec.ch    = kpsd_pkg::CHR_NONE;
		dec.blink = 1'b0;
		dec.nxt   = cur;
		unique case (code)
			kpsd_pkg::KEY_1: begin
				dec.ch = traction ? kpsd_pkg::CHR_A : kpsd_pkg::CHR_1;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_2: begin
				dec.ch = traction ? kpsd_pkg::CHR_B : kpsd_pkg::CHR_2;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_3: begin
				dec.ch = traction ? kpsd_pkg::CHR_C : kpsd_pkg::CHR_3;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_4: begin
				// no command in traction mode
				dec.ch = traction ? kpsd_pkg::CHR_NONE : kpsd_pkg::CHR_4;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_5: begin
				dec.ch = traction ? kpsd_pkg::CHR_NONE : kpsd_pkg::CHR_5;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_6: begin
				dec.ch = kpsd_pkg::CHR_6;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_7: begin
				dec.ch = kpsd_pkg::CHR_7;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_8: begin
				dec.ch = kpsd_pkg::CHR_8;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_9: begin
				dec.ch = kpsd_pkg::CHR_9;
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_STAR: begin
				dec.nxt.seq_first  = 1'b1;
				dec.nxt.seq_second = 1'b0;
			end
			kpsd_pkg::KEY_0: begin
				// seq_second is left alone on the fall-back path
				if (cur.seq_first && !cur.seq_second) begin
					dec.nxt.seq_second = 1'b1;
				end else begin
					dec.nxt.seq_first = 1'b0;
				end
			end
			kpsd_pkg::KEY_HASH: begin
				if (cur.seq_first && cur.seq_second) begin
					dec.nxt.mode = ~cur.mode;
					dec.blink    = 1'b1;
				end
				dec.nxt.seq_first  = 1'b0;
				dec.nxt.seq_second = 1'b0;
			end
			default: begin
				// unknown code, e.g. two keys down: consumed, no change
			end
		endcase
	end

endmodule

/* sv/keypad_scan_mode_code_decoder.sv */
// Top level of the 4x3 keypad scanner with radio/traction command encoding.
// Depends on kpsd_pkg, kpsd_if (kpsd_item_if, kpsd_result_if), kpsd_key_decode.
//
// Usage:
//   item   : sink channel. kind 0 carries the port byte read back while the
//            current row pattern is driven; kind 1 carries a received serial byte.
//   result : source channel, exactly one transfer per item, in order. row_drive
//            is the pattern to drive for the next sample; send_valid/send_char
//            carry a command character; blink_pulse flags a mode toggle;
//            led_level and control_mode show the current pin level and mode.
//   Path:    an item is taken into the input register, decoded and written to the
//            result register, from which its result transfers.
//   Throughput: one item per cycle while the receiver does not stall; the only loop
//            is the state flag update through one compare and the key decode table.
//   Reset (arst_n low): row 0 (EF) selected, scan armed, sequence flags clear,
//            radio mode, LED dark. Both pipeline stages empty.
//   Receiver stall: the result register holds; the input register still takes
//            one more item, after which item.ready drops until result moves.
module keypad_scan_mode_code_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	kpsd_item_if.sink            item,
	kpsd_result_if.source        result
);

	// Scan and mode state
	logic [1:0] row_idx_q;
	logic       armed_q;
	logic       seq_first_q;
	logic       seq_second_q;
	logic       mode_q;
	logic       led_q;

	// Input stage
	logic       v_s1;
	logic       kind_s1;
	logic [7:0] data_s1;

	// Result stage
	logic       v_s2;
	logic [7:0] row_drive_s2;
	logic       send_valid_s2;
	logic [7:0] send_char_s2;
	logic       blink_s2;
	logic       led_s2;
	logic       mode_s2;

	// Handshake
	logic adv_s1;   // input stage moves into the result stage
	logic take_in;  // transfer on the item channel

	assign adv_s1      = v_s1 && (!v_s2 || result.ready);
	assign item.ready  = !v_s1 || adv_s1;
	assign take_in     = item.valid && item.ready;

	// Decode path
	kpsd_pkg::key_state_t cur_flags;
	kpsd_pkg::key_dec_t   dec;
	logic                 is_sample;
	logic                 differs;
	logic                 do_decode;
	logic [1:0]           row_idx_nxt;
	logic                 armed_nxt;
	logic                 led_nxt;
	logic [7:0]           ch_out;

	assign cur_flags.seq_first  = seq_first_q;
	assign cur_flags.seq_second = seq_second_q;
	assign cur_flags.mode       = mode_q;

	kpsd_key_decode u_decode (
		.code (data_s1),
		.cur  (cur_flags),
		.dec  (dec)
	);

	assign is_sample = (kind_s1 == kpsd_pkg::KIND_SAMPLE);
	assign differs   = (data_s1 != kpsd_pkg::row_pattern(row_idx_q));
	// first differing sample after re-arm is the only one decoded
	assign do_decode = is_sample && differs && armed_q;
	assign ch_out    = do_decode ? dec.ch : kpsd_pkg::CHR_NONE;

	always_comb begin
		row_idx_nxt = row_idx_q;
		armed_nxt   = armed_q;
		led_nxt     = led_q;
		if (is_sample) begin
			if (differs) begin
				armed_nxt = 1'b0;
			end else begin
				// no key on this row: next row, re-arm
				row_idx_nxt = row_idx_q + 2'd1;
				armed_nxt   = 1'b1;
			end
		end else begin
			if (data_s1 == kpsd_pkg::SER_LED_ON) begin
				led_nxt = 1'b0;
			end else if (data_s1 == kpsd_pkg::SER_LED_OFF) begin
				led_nxt = 1'b1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= item.kind;
			data_s1 <= item.data_byte;
		end
	end

	// State update, one item per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q    <= 2'd0;
			armed_q      <= 1'b1;
			seq_first_q  <= 1'b0;
			seq_second_q <= 1'b0;
			mode_q       <= kpsd_pkg::MODE_RADIO;
			led_q        <= 1'b1;
		end else if (adv_s1) begin
			row_idx_q <= row_idx_nxt;
			armed_q   <= armed_nxt;
			led_q     <= led_nxt;
			if (do_decode) begin
				seq_first_q  <= dec.nxt.seq_first;
				seq_second_q <= dec.nxt.seq_second;
				mode_q       <= dec.nxt.mode;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (result.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_drive_s2  <= kpsd_pkg::row_pattern(row_idx_nxt);
			send_valid_s2 <= (ch_out != kpsd_pkg::CHR_NONE);
			send_char_s2  <= ch_out;
			blink_s2      <= do_decode && dec.blink;
			led_s2        <= led_nxt;
			mode_s2       <= do_decode ? dec.nxt.mode : mode_q;
		end
	end

	assign result.valid        = v_s2;
	assign result.row_drive    = row_drive_s2;
	assign result.send_valid   = send_valid_s2;
	assign result.send_char    = send_char_s2;
	assign result.blink_pulse  = blink_s2;
	assign result.led_level    = led_s2;
	assign result.control_mode = mode_s2;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for keypad_scan_mode_code_decoder: a directed table, then random scans.
// Depends on kpsd_pkg, kpsd_if (kpsd_item_if, kpsd_result_if) and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import kpsd_pkg::*;

	// One result transfer as the block presents it
	typedef struct packed {
		logic [7:0] row_drive;
		logic       send_valid;
		logic [7:0] send_char;
		logic       blink_pulse;
		logic       led_level;
		logic       control_mode;
	} scan_result_t;

	// Directed stimulus row; want is used only where typed is set
	typedef struct packed {
		logic         kind;
		logic [7:0]   data;
		logic         typed;
		scan_result_t want;
	} scan_dir_row_t;

	// Planned random item; rearm means "drive back the current row pattern"
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       rearm;
	} scan_token_t;

	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;     // two-stage pipe, plus margin
	localparam int unsigned IDLE_PCT     = 24;
	localparam int unsigned QUIET_FROM   = 700;   // no idling on either side in this window
	localparam int unsigned QUIET_TO     = 1000;
	localparam int unsigned REPORT_MAX   = 10;

	localparam logic [7:0] ROW_DRIVES [4] = '{8'hEF, 8'hDF, 8'hBF, 8'h7F};

	localparam logic [7:0] KEY_CODES [12] = '{
		KEY_1, KEY_2, KEY_3, KEY_4, KEY_5, KEY_6,
		KEY_7, KEY_8, KEY_9, KEY_STAR, KEY_0, KEY_HASH
	};

	localparam scan_token_t REARM_TOKEN = '{KIND_SAMPLE, 8'h00, 1'b1};

	// Walked from reset. Typed rows: reset/extreme/held/ignored cases whose
	// result is plain; all others come from the predictor.
	localparam int DIR_ROWS = 26;
	localparam scan_dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// first release: row 0 matches, scan moves to row 1
		'{KIND_SAMPLE, 8'hEF, 1'b1, '{8'hDF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_RADIO}},
		// all-low byte, no such key: consumed, disarms
		'{KIND_SAMPLE, 8'h00, 1'b1, '{8'hDF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_RADIO}},
		// all-high byte while disarmed: held, nothing moves
		'{KIND_SAMPLE, 8'hFF, 1'b1, '{8'hDF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_RADIO}},
		'{KIND_SAMPLE, 8'hDF, 1'b1, '{8'hBF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_RADIO}},
		'{KIND_SAMPLE, KEY_1,    1'b0, '0},
		'{KIND_SAMPLE, 8'hBF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_0,    1'b0, '0},  // zero with no star before it
		'{KIND_SAMPLE, 8'h7F,    1'b0, '0},
		'{KIND_SAMPLE, KEY_HASH, 1'b0, '0},  // hash with no sequence
		'{KIND_SAMPLE, 8'hEF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_STAR, 1'b0, '0},  // star, 0, hash: mode toggle
		'{KIND_SAMPLE, 8'hDF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_0,    1'b0, '0},
		'{KIND_SAMPLE, 8'hBF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_HASH, 1'b0, '0},
		'{KIND_SAMPLE, 8'h7F,    1'b0, '0},
		'{KIND_SAMPLE, KEY_1,    1'b0, '0},  // traction code for key 1
		'{KIND_SAMPLE, 8'hEF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_4,    1'b0, '0},  // key 4 sends nothing in traction
		'{KIND_SAMPLE, 8'hDF,    1'b0, '0},
		'{KIND_SERIAL, SER_LED_ON,  1'b0, '0},
		'{KIND_SERIAL, SER_LED_OFF, 1'b0, '0},
		// other serial bytes are ignored
		'{KIND_SERIAL, 8'h00, 1'b1, '{8'hBF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_TRACTION}},
		'{KIND_SERIAL, 8'hFF, 1'b1, '{8'hBF, 1'b0, CHR_NONE, 1'b0, 1'b1, MODE_TRACTION}},
		'{KIND_SAMPLE, 8'hBF,    1'b0, '0},
		'{KIND_SAMPLE, KEY_6,    1'b0, '0}
	};

	logic clk;
	logic arst_n;

	kpsd_item_if   item_ch ();
	kpsd_result_if result_ch ();

	keypad_scan_mode_code_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Predictor state, mirrors the block after every accepted item
	logic [1:0] scan_row;
	logic       scan_armed;
	logic       star_seen;
	logic       zero_seen;
	logic       scan_mode;
	logic       led_pin;

	scan_result_t due_results [$];   // expected results, oldest first
	scan_token_t  plan_q [$];        // random items not yet driven

	int unsigned accepted_items;
	int unsigned fail_count;
	int unsigned cycle_count;
	logic        cur_typed;
	scan_result_t cur_want;

	// Work out one item's result and advance the predictor state.
	task automatic decode_scan_item(input logic kind_i, input logic [7:0] byte_i,
			output scan_result_t res);
		logic [7:0] ch;
		logic       blink;
		ch    = CHR_NONE;
		blink = 1'b0;
		if (kind_i == KIND_SAMPLE) begin
			if (byte_i != ROW_DRIVES[scan_row]) begin
				// a key is down; only the first sample after re-arm counts
				if (scan_armed) begin
					scan_armed = 1'b0;
					case (byte_i)
						KEY_1: ch = (scan_mode == MODE_TRACTION) ? CHR_A : CHR_1;
						KEY_2: ch = (scan_mode == MODE_TRACTION) ? CHR_B : CHR_2;
						KEY_3: ch = (scan_mode == MODE_TRACTION) ? CHR_C : CHR_3;
						KEY_4: ch = (scan_mode == MODE_TRACTION) ? CHR_NONE : CHR_4;
						KEY_5: ch = (scan_mode == MODE_TRACTION) ? CHR_NONE : CHR_5;
						KEY_6: ch = CHR_6;
						KEY_7: ch = CHR_7;
						KEY_8: ch = CHR_8;
						KEY_9: ch = CHR_9;
						KEY_STAR: begin
							star_seen = 1'b1;
							zero_seen = 1'b0;
						end
						KEY_0: begin
							if (star_seen && !zero_seen)
								zero_seen = 1'b1;
							else
								star_seen = 1'b0;
						end
						KEY_HASH: begin
							if (star_seen && zero_seen) begin
								scan_mode = ~scan_mode;
								blink     = 1'b1;
							end
							star_seen = 1'b0;
							zero_seen = 1'b0;
						end
						default: ;  // unknown code: consumed only
					endcase
					// any digit breaks the sequence, sent or not
					case (byte_i)
						KEY_1, KEY_2, KEY_3, KEY_4, KEY_5, KEY_6, KEY_7, KEY_8, KEY_9: begin
							star_seen = 1'b0;
							zero_seen = 1'b0;
						end
						default: ;
					endcase
				end
			end else begin
				// released: next row, re-arm
				scan_row   = scan_row + 2'd1;
				scan_armed = 1'b1;
			end
		end else begin
			if (byte_i == SER_LED_ON)
				led_pin = 1'b0;
			else if (byte_i == SER_LED_OFF)
				led_pin = 1'b1;
		end
		res.row_drive    = ROW_DRIVES[scan_row];
		res.send_valid   = (ch != CHR_NONE);
		res.send_char    = ch;
		res.blink_pulse  = blink;
		res.led_level    = led_pin;
		res.control_mode = scan_mode;
	endtask

	// Queue the next burst of random items. Mostly well-formed key presses
	// and mode sequences with releases between them, some noise and serial.
	task automatic plan_refill();
		int unsigned pick;
		logic [7:0]  mid_key;
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			// star, 0, hash; one in four gets a stray key in the middle
			mid_key = KEY_0;
			if ($urandom_range(0, 3) == 0)
				mid_key = KEY_CODES[$urandom_range(0, 11)];
			plan_q.push_back('{KIND_SAMPLE, KEY_STAR, 1'b0});
			plan_q.push_back(REARM_TOKEN);
			plan_q.push_back('{KIND_SAMPLE, mid_key, 1'b0});
			plan_q.push_back(REARM_TOKEN);
			plan_q.push_back('{KIND_SAMPLE, KEY_HASH, 1'b0});
			plan_q.push_back(REARM_TOKEN);
		end else if (pick < 46) begin
			plan_q.push_back('{KIND_SAMPLE, KEY_CODES[$urandom_range(0, 11)], 1'b0});
			if ($urandom_range(0, 2) == 0)
				plan_q.push_back('{KIND_SAMPLE, 8'($urandom_range(0, 255)), 1'b0});
			if ($urandom_range(0, 9) < 7)
				plan_q.push_back(REARM_TOKEN);
		end else if (pick < 62) begin
			plan_q.push_back(REARM_TOKEN);
		end else if (pick < 72) begin
			plan_q.push_back('{KIND_SAMPLE, 8'($urandom_range(0, 255)), 1'b0});
		end else begin
			case ($urandom_range(0, 2))
				0:       plan_q.push_back('{KIND_SERIAL, SER_LED_ON, 1'b0});
				1:       plan_q.push_back('{KIND_SERIAL, SER_LED_OFF, 1'b0});
				default: plan_q.push_back('{KIND_SERIAL, 8'($urandom_range(0, 255)), 1'b0});
			endcase
		end
	endtask

	function automatic logic quiet_window();
		return accepted_items >= QUIET_FROM && accepted_items < QUIET_TO;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Source side: drive items, predict each at its transfer, then drain and finish.
	initial begin : item_source
		int unsigned  dir_idx;
		int unsigned  rand_count;
		logic         holding;
		scan_token_t  tok;
		scan_result_t predicted;

		item_ch.valid     = 1'b0;
		item_ch.kind      = KIND_SAMPLE;
		item_ch.data_byte = 8'h00;
		scan_row       = 2'd0;
		scan_armed     = 1'b1;
		star_seen      = 1'b0;
		zero_seen      = 1'b0;
		scan_mode      = MODE_RADIO;
		led_pin        = 1'b1;
		accepted_items = 0;
		fail_count     = 0;
		cur_typed      = 1'b0;
		cur_want       = '0;
		dir_idx        = 0;
		rand_count     = 0;
		holding        = 1'b0;

		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (item_ch.valid && item_ch.ready) begin
				decode_scan_item(item_ch.kind, item_ch.data_byte, predicted);
				due_results.push_back(cur_typed ? cur_want : predicted);
				accepted_items++;
				holding = 1'b0;
			end
			// an item not yet taken stays on the bus untouched
			if (!holding) begin
				if (dir_idx >= DIR_ROWS && rand_count >= RANDOM_ITEMS) begin
					item_ch.valid <= 1'b0;
					break;
				end
				if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
					item_ch.valid <= 1'b0;
				end else begin
					if (dir_idx < DIR_ROWS) begin
						item_ch.kind      <= DIR_TABLE[dir_idx].kind;
						item_ch.data_byte <= DIR_TABLE[dir_idx].data;
						cur_typed = DIR_TABLE[dir_idx].typed;
						cur_want  = DIR_TABLE[dir_idx].want;
						dir_idx++;
					end else begin
						if (plan_q.size() == 0)
							plan_refill();
						tok = plan_q.pop_front();
						// state is current: every earlier item has transferred
						item_ch.kind      <= tok.kind;
						item_ch.data_byte <= tok.rearm ? ROW_DRIVES[scan_row] : tok.data;
						cur_typed = 1'b0;
						rand_count++;
					end
					item_ch.valid <= 1'b1;
					holding = 1'b1;
				end
			end
		end

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0d expected results never arrived", due_results.size());
			fail_count += due_results.size();
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Sink side: random back-pressure, and check every result transfer.
	initial begin : result_sink
		scan_result_t got_r;
		scan_result_t want_r;
		logic         bad;

		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got_r.row_drive    = result_ch.row_drive;
				got_r.send_valid   = result_ch.send_valid;
				got_r.send_char    = result_ch.send_char;
				got_r.blink_pulse  = result_ch.blink_pulse;
				got_r.led_level    = result_ch.led_level;
				got_r.control_mode = result_ch.control_mode;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result: row %h sv %b ch %h blink %b led %b mode %b",
							got_r.row_drive, got_r.send_valid, got_r.send_char,
							got_r.blink_pulse, got_r.led_level, got_r.control_mode);
				end else begin
					want_r = due_results.pop_front();
					bad = (got_r.row_drive    !== want_r.row_drive)
					   || (got_r.send_valid   !== want_r.send_valid)
					   || (got_r.send_char    !== want_r.send_char)
					   || (got_r.blink_pulse  !== want_r.blink_pulse)
					   || (got_r.led_level    !== want_r.led_level)
					   || (got_r.control_mode !== want_r.control_mode);
					if (bad) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display({"mismatch: want row %h sv %b ch %h blink %b led %b mode %b,",
								" got row %h sv %b ch %h blink %b led %b mode %b"},
								want_r.row_drive, want_r.send_valid, want_r.send_char,
								want_r.blink_pulse, want_r.led_level, want_r.control_mode,
								got_r.row_drive, got_r.send_valid, got_r.send_char,
								got_r.blink_pulse, got_r.led_level, got_r.control_mode);
					end
				end
			end
			result_ch.ready <= arst_n && (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

endmodule
